>>> rtl/ftc_pkg.sv
`default_nettype none

package ftc_pkg;

  localparam int MAX_NODES = 512;
  localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NODE_W    = 9;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [NODE_W-1:0] node_t;

  typedef struct packed {
    logic mark;
    idx_t link;
  } entry_t;

  typedef struct packed {
    logic   en;
    idx_t   addr;
    entry_t data;
  } mem_wr_t;

endpackage

`default_nettype wire

>>> rtl/ftc_link_ram.sv
`default_nettype none

module ftc_link_ram (
  input  logic             clk,
  input  ftc_pkg::mem_wr_t wr,
  input  ftc_pkg::idx_t    rd_addr,
  output ftc_pkg::entry_t  rd_data
);
  import ftc_pkg::*;

  entry_t mem [MAX_NODES];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // A read of the address being written returns the new entry.
  always_ff @(posedge clk) begin
    if (wr.en && (wr.addr == rd_addr)) begin
      rd_data_r <= wr.data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/forest_tree_counter_core.sv
`default_nettype none

// Counts the acyclic connected components of an undirected graph whose edges
// arrive one beat at a time (in_cmd 0), using a union-find link table held in
// one memory with one write and one read port that a small sequencer walks
// one link per cycle. After an edge beat is accepted, in_ready stays low while
// the block walks the links from each endpoint to its root and updates the
// roots, with a second root write when the edge joins two components; an edge
// with an endpoint outside the table is dropped and leaves in_ready high. After
// a finish beat (in_cmd 1), in_ready stays low while the block walks nodes
// 1..node_count (saturated to the last table index) to their roots, until it
// hands tree_count to the output register, and then while the table is
// cleared. The same clearing pass runs after reset. The count waits in an
// output register, so a slow consumer only stalls the block at the end of the
// next finish beat.
module forest_tree_counter_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  ftc_pkg::node_t cfg_wdata,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_cmd,
  input  ftc_pkg::node_t in_node_a,
  input  ftc_pkg::node_t in_node_b,
  output logic           out_valid,
  input  logic           out_ready,
  output ftc_pkg::node_t out_tree_count
);
  import ftc_pkg::*;

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_FIND_A   = 3'd2;
  localparam logic [2:0] ST_FIND_B   = 3'd3;
  localparam logic [2:0] ST_JOIN     = 3'd4;
  localparam logic [2:0] ST_FIN_WALK = 3'd5;
  localparam logic [2:0] ST_FIN_DONE = 3'd6;

  localparam logic CMD_EDGE   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam idx_t LAST_IDX = idx_t'(MAX_NODES - 1);

  logic [2:0] state_r, state_nxt;
  idx_t       cur_r, cur_nxt;
  idx_t       b_r, b_nxt;
  idx_t       ra_r, ra_nxt;
  logic       mark_r, mark_nxt;
  idx_t       iter_r, iter_nxt;
  idx_t       clr_r, clr_nxt;
  node_t      count_r, count_nxt;
  node_t      node_count_r;
  logic       out_valid_r, out_valid_nxt;
  node_t      out_count_r, out_count_nxt;

  mem_wr_t    wr;
  entry_t     rd_data;
  idx_t       limit;
  logic       at_root;
  logic       edge_ok;
  logic       accept;

  ftc_link_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (cur_nxt),
    .rd_data (rd_data)
  );

  assign limit   = (int'(node_count_r) > MAX_NODES - 1) ? LAST_IDX : idx_t'(node_count_r);
  assign at_root = (rd_data.link == cur_r);
  assign edge_ok = (int'(in_node_a) < MAX_NODES) && (int'(in_node_b) < MAX_NODES);
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    b_nxt         = b_r;
    ra_nxt        = ra_r;
    mark_nxt      = mark_r;
    iter_nxt      = iter_r;
    clr_nxt       = clr_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_count_nxt = out_count_r;
    wr            = '0;

    unique case (state_r)
      ST_CLEAR: begin
        wr.en        = 1'b1;
        wr.addr      = clr_r;
        wr.data.mark = 1'b0;
        wr.data.link = clr_r;
        clr_nxt      = clr_r + idx_t'(1);
        if (clr_r == LAST_IDX) begin
          clr_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_EDGE) begin
            if (edge_ok) begin
              cur_nxt   = idx_t'(in_node_a);
              b_nxt     = idx_t'(in_node_b);
              state_nxt = ST_FIND_A;
            end
          end else begin
            count_nxt = '0;
            if (limit == '0) begin
              state_nxt = ST_FIN_DONE;
            end else begin
              iter_nxt  = idx_t'(1);
              cur_nxt   = idx_t'(1);
              state_nxt = ST_FIN_WALK;
            end
          end
        end
      end
      ST_FIND_A: begin
        if (at_root) begin
          ra_nxt    = cur_r;
          mark_nxt  = rd_data.mark;
          cur_nxt   = b_r;
          state_nxt = ST_FIND_B;
        end else begin
          cur_nxt = rd_data.link;
        end
      end
      ST_FIND_B: begin
        if (at_root) begin
          wr.en = 1'b1;
          if (cur_r == ra_r) begin
            wr.addr      = ra_r;
            wr.data.mark = 1'b1;
            wr.data.link = ra_r;
            state_nxt    = ST_IDLE;
          end else begin
            wr.addr      = cur_r;
            wr.data.mark = rd_data.mark;
            wr.data.link = ra_r;
            mark_nxt     = mark_r | rd_data.mark;
            state_nxt    = ST_JOIN;
          end
        end else begin
          cur_nxt = rd_data.link;
        end
      end
      ST_JOIN: begin
        wr.en        = 1'b1;
        wr.addr      = ra_r;
        wr.data.mark = mark_r;
        wr.data.link = ra_r;
        state_nxt    = ST_IDLE;
      end
      ST_FIN_WALK: begin
        if (at_root) begin
          if (!rd_data.mark) begin
            count_nxt    = count_r + node_t'(1);
            wr.en        = 1'b1;
            wr.addr      = cur_r;
            wr.data.mark = 1'b1;
            wr.data.link = cur_r;
          end
          if (iter_r == limit) begin
            state_nxt = ST_FIN_DONE;
          end else begin
            iter_nxt = iter_r + idx_t'(1);
            cur_nxt  = iter_r + idx_t'(1);
          end
        end else begin
          cur_nxt = rd_data.link;
        end
      end
      ST_FIN_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_r;
          clr_nxt       = '0;
          state_nxt     = ST_CLEAR;
        end
      end
      default: begin
        clr_nxt   = '0;
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
      node_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    b_r         <= b_nxt;
    ra_r        <= ra_nxt;
    mark_r      <= mark_nxt;
    iter_r      <= iter_nxt;
    count_r     <= count_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_tree_count = out_count_r;

endmodule

`default_nettype wire

>>> verif/tb_forest_tree_counter_core.sv
`default_nettype none

module tb_forest_tree_counter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ftc_pkg::*;

  localparam logic CMD_EDGE   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;
  localparam int CLEAR_WAIT   = MAX_NODES + 100;
  localparam int CYCLE_LIMIT  = 20_000_000;
  localparam int HOLD_CYCLES  = 3000;

  logic  clk;
  logic  rst_n;
  logic  cfg_we;
  node_t cfg_wdata;
  logic  in_valid;
  logic  in_ready;
  logic  in_cmd;
  node_t in_node_a;
  node_t in_node_b;
  logic  out_valid;
  logic  out_ready;
  node_t out_tree_count;

  forest_tree_counter_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_node_a      (in_node_a),
    .in_node_b      (in_node_b),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_tree_count (out_tree_count)
  );

  node_t forest_link [MAX_NODES];
  bit    forest_cyclic [MAX_NODES];
  node_t graph_nodes;
  node_t tree_counts_due [$];

  int errors;
  int beats_sent;
  int cycle_cnt;
  int rx_wait;
  int ready_hold;
  bit tx_steady;
  bit rx_steady;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  function automatic int unsigned root_of(int unsigned v);
    int unsigned steps;
    steps = 0;
    while (32'(forest_link[v]) != v && steps < MAX_NODES) begin
      v = 32'(forest_link[v]) % MAX_NODES;
      steps++;
    end
    return v;
  endfunction

  function automatic void clear_forest();
    for (int i = 0; i < MAX_NODES; i++) begin
      forest_link[i]   = node_t'(i);
      forest_cyclic[i] = 1'b0;
    end
  endfunction

  function automatic void join_nodes(node_t a, node_t b);
    int unsigned ra, rb;
    if (int'(a) >= MAX_NODES || int'(b) >= MAX_NODES) return;
    ra = root_of(32'(a));
    rb = root_of(32'(b));
    if (ra == rb) begin
      forest_cyclic[ra] = 1'b1;
    end else begin
      forest_link[rb]   = node_t'(ra);
      forest_cyclic[ra] = forest_cyclic[ra] | forest_cyclic[rb];
    end
  endfunction

  function automatic node_t count_trees();
    int unsigned lim, cnt, r;
    lim = 32'(graph_nodes);
    cnt = 0;
    if (lim > MAX_NODES - 1) lim = MAX_NODES - 1;
    for (int unsigned i = 1; i <= lim; i++) begin
      r = root_of(i);
      if (!forest_cyclic[r]) begin
        cnt++;
        forest_cyclic[r] = 1'b1;
      end
    end
    clear_forest();
    return node_t'(cnt);
  endfunction

  task automatic send_beat(input logic cmd, input node_t a, input node_t b);
    int    gap;
    node_t due;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_cmd    <= cmd;
    in_node_a <= a;
    in_node_b <= b;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    if (cmd == CMD_FINISH) begin
      due = count_trees();
      tree_counts_due = {tree_counts_due, due};
    end else begin
      join_nodes(a, b);
    end
  endtask

  task automatic send_edge(input node_t a, input node_t b);
    send_beat(CMD_EDGE, a, b);
  endtask

  task automatic send_finish();
    send_beat(CMD_FINISH, node_t'($urandom), node_t'($urandom));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tree_counts_due.size() != 0) @(posedge clk);
    repeat (CLEAR_WAIT) @(posedge clk);
  endtask

  task automatic set_node_count(input node_t n);
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we      <= 1'b0;
    graph_nodes = n;
  endtask

  task automatic send_graph();
    int unsigned kind, n_edges, span, start, len;
    node_t a, b;
    kind = $urandom_range(0, 9);
    span = graph_nodes + 2;
    if (span > MAX_NODES - 1) span = MAX_NODES - 1;
    if (span < 3) span = 3;
    if (kind < 2) begin
      start = $urandom_range(0, span);
      len   = $urandom_range(2, 16);
      for (int unsigned k = 0; k < len; k++) begin
        a = node_t'(start + k + 1);
        b = node_t'(start + k);
        if ($urandom_range(0, 1) == 1) send_edge(b, a);
        else send_edge(a, b);
      end
      if ($urandom_range(0, 3) == 0) send_edge(node_t'(start), node_t'(start + len));
    end else begin
      n_edges = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      for (int unsigned k = 0; k < n_edges; k++) begin
        if (kind == 2 || $urandom_range(0, 19) == 0) begin
          a = node_t'($urandom);
          b = node_t'($urandom);
        end else begin
          a = node_t'($urandom_range(0, span));
          b = node_t'($urandom_range(0, span));
        end
        send_edge(a, b);
      end
    end
    send_finish();
  endtask

  task automatic test_empty_graph();
    wait_idle();
    set_node_count(node_t'(0));
    send_finish();
    send_edge(node_t'(1), node_t'(2));
    send_finish();
  endtask

  task automatic test_full_table();
    wait_idle();
    set_node_count(node_t'(MAX_NODES - 1));
    send_finish();
    send_edge(node_t'(511), node_t'(1));
    send_edge(node_t'(0), node_t'(511));
    send_edge(node_t'(0), node_t'(0));
    send_finish();
  endtask

  task automatic test_cycles_and_outsiders();
    wait_idle();
    set_node_count(node_t'(10));
    send_edge(node_t'(5), node_t'(5));
    send_edge(node_t'(3), node_t'(4));
    send_edge(node_t'(4), node_t'(3));
    send_edge(node_t'(6), node_t'(7));
    send_edge(node_t'(7), node_t'(8));
    send_edge(node_t'(8), node_t'(6));
    send_edge(node_t'(2), node_t'(1));
    send_edge(node_t'(10), node_t'(300));
    send_edge(node_t'(300), node_t'(400));
    send_edge(node_t'(400), node_t'(10));
    send_edge(node_t'(9), node_t'(450));
    send_edge(node_t'(450), node_t'(500));
    send_finish();
  endtask

  task automatic test_output_stall();
    wait_idle();
    set_node_count(node_t'(20));
    tx_steady  = 1'b1;
    ready_hold = HOLD_CYCLES;
    repeat (5) send_graph();
    tx_steady = 1'b0;
  endtask

  task automatic test_random_graphs();
    node_t nc;
    int    stop;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: nc = node_t'(1);
        1: nc = node_t'(MAX_NODES - 1);
        2: nc = node_t'(0);
        3: nc = node_t'($urandom_range(2, 15));
        4: nc = node_t'($urandom_range(16, 64));
        5: nc = node_t'(3);
        6: nc = node_t'($urandom_range(0, MAX_NODES - 1));
        default: nc = node_t'(MAX_NODES - 1);
      endcase
      wait_idle();
      set_node_count(nc);
      tx_steady = (p == 2 || p == 5);
      rx_steady = tx_steady;
      stop = beats_sent + 190;
      while (beats_sent < stop) send_graph();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold--;
    end else if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait--;
    end else begin
      out_ready <= 1'b1;
      if (!rx_steady && $urandom_range(0, 3) == 0) rx_wait = pick_gap();
    end
  end

  always @(posedge clk) begin
    node_t due;
    if (rst_n && out_valid && out_ready) begin
      if (tree_counts_due.size() == 0) begin
        $error("tree_count: expected none, actual %0d", out_tree_count);
        errors++;
      end else begin
        due = tree_counts_due.pop_front();
        if (out_tree_count !== due) begin
          $error("tree_count: expected %0d, actual %0d", due, out_tree_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("forest_tree_counter_core: mismatch");
      $finish;
    end
  end

  initial begin
    errors      = 0;
    beats_sent  = 0;
    cycle_cnt   = 0;
    rx_wait     = 0;
    ready_hold  = 0;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    graph_nodes = node_t'(0);
    clear_forest();
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= node_t'(0);
    in_valid  <= 1'b0;
    in_cmd    <= CMD_EDGE;
    in_node_a <= node_t'(0);
    in_node_b <= node_t'(0);
    out_ready <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_graph();
    test_full_table();
    test_cycles_and_outsiders();
    test_output_stall();
    test_random_graphs();

    wait_idle();
    if (errors == 0) begin
      $display("forest_tree_counter_core: match");
    end else begin
      $display("forest_tree_counter_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
